// ===== rtl/core/lpd_pkg.sv =====
// types and constants shared by the length-prefixed deframer
`default_nettype none

package lpd_pkg;

   localparam int DEF_MAX_BODY_BYTES = 65532;
   localparam int HEADER_BYTES       = 4;
   localparam int HDR_CNT_W          = 3;
   localparam int BODY_W             = 16;
   localparam int LEN_W              = 32;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_OPEN  = 2'd2;

   localparam logic STATUS_PAYLOAD    = 1'b0;
   localparam logic STATUS_BAD_LENGTH = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [7:0]       payload_byte;
      logic             last_byte;
      logic [LEN_W-1:0] message_length;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/length_prefixed_deframer.sv =====
// length-prefixed deframer: 4-byte big-endian header, then body words
// result words are registered: a result appears in the cycle after its input word is accepted
// throughput: one input word per cycle while req_stall is low; framing state updates in the accept cycle
// req_stall is high only while a result word sits in the output register and is stalled
// reset: synchronous, active high; stream open, all framing counters cleared
`default_nettype none

module length_prefixed_deframer #(
   parameter int MAX_BODY_BYTES = lpd_pkg::DEF_MAX_BODY_BYTES
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  lpd_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output lpd_pkg::rsp_type  rsp_payload
);
   import lpd_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BODY_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_FULL = HDR_CNT_W'(HEADER_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

   logic                 open_ff,      open_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff,   hdr_cnt_in;
   logic [LEN_W-1:0]     shift_ff,     shift_in;
   logic [BODY_W-1:0]    body_len_ff,  body_len_in;
   logic [BODY_W-1:0]    body_cnt_ff,  body_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff,       rsp_in;

   logic              accept;
   logic              emit;
   logic [LEN_W-1:0]  new_len;
   logic [BODY_W-1:0] next_cnt;
   logic              is_last;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign new_len  = {shift_ff[LEN_W-9:0], req_payload.data_byte};
   assign next_cnt = body_cnt_ff + BODY_W'(1);
   assign is_last  = (next_cnt == body_len_ff);

   always_comb begin
      open_in     = open_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      shift_in    = shift_ff;
      body_len_in = body_len_ff;
      body_cnt_in = body_cnt_ff;
      emit        = 1'b0;
      rsp_in      = rsp_ff;
      if (accept) begin
         unique case (req_payload.kind)
            KIND_OPEN: begin
               open_in     = 1'b1;
               hdr_cnt_in  = '0;
               shift_in    = '0;
               body_len_in = '0;
               body_cnt_in = '0;
            end
            KIND_CLOSE: begin
               open_in = 1'b0;
            end
            KIND_DATA: begin
               if (open_ff) begin
                  if (hdr_cnt_ff != HDR_FULL) begin
                     shift_in   = new_len;
                     hdr_cnt_in = hdr_cnt_ff + HDR_CNT_W'(1);
                     if (hdr_cnt_ff == HDR_LAST) begin
                        if (new_len == '0 || new_len > MAX_LEN) begin
                           open_in                = 1'b0;
                           emit                   = 1'b1;
                           rsp_in.status          = STATUS_BAD_LENGTH;
                           rsp_in.payload_byte    = '0;
                           rsp_in.last_byte       = 1'b0;
                           rsp_in.message_length  = new_len;
                        end else begin
                           body_len_in = new_len[BODY_W-1:0];
                           body_cnt_in = '0;
                        end
                     end
                  end else begin
                     emit                  = 1'b1;
                     rsp_in.status         = STATUS_PAYLOAD;
                     rsp_in.payload_byte   = req_payload.data_byte;
                     rsp_in.last_byte      = is_last;
                     rsp_in.message_length = LEN_W'(body_len_ff);
                     body_cnt_in           = next_cnt;
                     if (is_last) begin
                        hdr_cnt_in  = '0;
                        shift_in    = '0;
                        body_len_in = '0;
                        body_cnt_in = '0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b1;
         hdr_cnt_ff   <= '0;
         shift_ff     <= '0;
         body_len_ff  <= '0;
         body_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         shift_ff     <= shift_in;
         body_len_ff  <= body_len_in;
         body_cnt_ff  <= body_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   a_hdr_cnt_range: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HDR_FULL)
      else $error("header count out of range");

   a_body_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      body_cnt_ff <= body_len_ff)
      else $error("body count beyond message length");

   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_PAYLOAD |->
         rsp_ff.message_length != '0 && rsp_ff.message_length <= MAX_LEN)
      else $error("payload word with illegal message length");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_in.status == STATUS_BAD_LENGTH |=> !open_ff)
      else $error("stream still open after bad length");

   a_open_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.kind == KIND_OPEN |=>
         open_ff && hdr_cnt_ff == '0 && body_cnt_ff == '0)
      else $error("open word did not clear framing");

endmodule

`default_nettype wire

// ===== verif/length_prefixed_deframer_tb.sv =====
// self-checking testbench for the length-prefixed deframer
module length_prefixed_deframer_tb;
   import lpd_pkg::*;

   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam logic [31:0] MAX_LEN     = 32'(DEF_MAX_BODY_BYTES);
   localparam int          RANDOM_WORDS = 600;
   localparam int          CYCLE_LIMIT  = 500000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   rsp_type due_words[$];
   int      err_count = 0;
   int      cycles = 0;
   logic    no_idle = 1'b0;

   // shadow of the framing state
   logic        open_s;
   logic [2:0]  hdr_cnt;
   logic [31:0] len_acc;
   logic [15:0] body_len;
   logic [15:0] body_cnt;

   logic    rsp_fire;
   rsp_type rsp_seen;

   length_prefixed_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("length_prefixed_deframer_tb: done, errors");
         $finish;
      end
   end

   task automatic report(input string msg);
      if (err_count < 100) $display("%0t mismatch: %s", $time, msg);
      err_count++;
   endtask

   task automatic clear_framing;
      hdr_cnt  = '0;
      len_acc  = '0;
      body_len = '0;
      body_cnt = '0;
   endtask

   task automatic apply_word(input logic [1:0] kind, input logic [7:0] data);
      rsp_type w;
      w = '0;
      case (kind)
         KIND_OPEN: begin
            clear_framing();
            open_s = 1'b1;
         end
         KIND_CLOSE: begin
            open_s = 1'b0;
         end
         KIND_DATA: begin
            if (open_s && hdr_cnt < HEADER_BYTES) begin
               len_acc = {len_acc[23:0], data};
               hdr_cnt = hdr_cnt + 3'd1;
               if (hdr_cnt == HEADER_BYTES) begin
                  if (len_acc == 32'd0 || len_acc > MAX_LEN) begin
                     open_s = 1'b0;
                     w.status = STATUS_BAD_LENGTH;
                     w.message_length = len_acc;
                     due_words.push_back(w);
                  end else begin
                     body_len = len_acc[15:0];
                     body_cnt = '0;
                  end
               end
            end else if (open_s) begin
               body_cnt = body_cnt + 16'd1;
               w.status = STATUS_PAYLOAD;
               w.payload_byte = data;
               w.last_byte = (body_cnt == body_len);
               w.message_length = {16'd0, body_len};
               due_words.push_back(w);
               if (w.last_byte) clear_framing();
            end
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
      int      gap;
      logic    taken;
      req_type r;
      gap = pick_gap();
      r.kind = kind;
      r.data_byte = data;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      apply_word(kind, data);
   endtask

   // header then random body, stopping after upto words
   task automatic send_message(input logic [31:0] len, input int upto);
      int i;
      for (i = 0; i < 4 && i < upto; i++)
         send_word(KIND_DATA, len[31-8*i -: 8]);
      for (i = 4; i < int'(len) + 4 && i < upto; i++)
         send_word(KIND_DATA, 8'($urandom()));
   endtask

   task automatic wait_idle;
      req_valid <= 1'b0;
      do @(posedge clock); while (due_words.size() != 0);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 48);
      return $urandom_range(250, 300);
   endfunction

   function automatic logic [31:0] pick_bad_length();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return 32'($urandom_range(int'(MAX_LEN) + 1, 65535));
         2: return $urandom() | 32'h0001_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // receiver stall pattern
   initial begin
      int run;
      int hold;
      forever begin
         if (no_idle) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            run = $urandom_range(1, 6);
            hold = ($urandom_range(99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            rsp_stall <= 1'b0;
            repeat (run) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // result checker
   always begin
      rsp_type want;
      @(negedge clock);
      rsp_fire = rsp_valid && !rsp_stall && !reset;
      rsp_seen = rsp_payload;
      @(posedge clock);
      if (rsp_fire) begin
         if (due_words.size() == 0) begin
            report($sformatf("unexpected word %h", rsp_seen));
         end else begin
            want = due_words.pop_front();
            if (rsp_seen.status !== want.status)
               report($sformatf("status %b, want %b", rsp_seen.status, want.status));
            if (rsp_seen.payload_byte !== want.payload_byte)
               report($sformatf("payload_byte %h, want %h",
                                rsp_seen.payload_byte, want.payload_byte));
            if (rsp_seen.last_byte !== want.last_byte)
               report($sformatf("last_byte %b, want %b", rsp_seen.last_byte, want.last_byte));
            if (rsp_seen.message_length !== want.message_length)
               report($sformatf("message_length %h, want %h",
                                rsp_seen.message_length, want.message_length));
         end
      end
   end

   task automatic test_length_extremes;
      // shortest message, with an unused kind inside the header
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_UNUSED, 8'hFF);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'h01);
      send_word(KIND_DATA, 8'hAB);
      // longest message, cut short by a close
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'hFF);
      send_word(KIND_DATA, 8'hFC);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'hFF);
      send_word(KIND_CLOSE, 8'h00);
   endtask

   task automatic test_closed_stream;
      send_word(KIND_DATA, 8'h5A);
      send_word(KIND_CLOSE, 8'hFF);
      send_word(KIND_OPEN, 8'h00);
   endtask

   task automatic test_bad_lengths;
      send_message(32'd0, 4);
      send_word(KIND_DATA, 8'h55);
      send_word(KIND_OPEN, 8'h00);
      send_message(32'hFFFF_FFFF, 4);
      send_word(KIND_OPEN, 8'hFF);
   endtask

   task automatic test_random_stream;
      int   sent;
      int   pick;
      int   len;
      int   cut;
      int   i;
      logic drained;
      sent = 0;
      drained = 1'b0;
      while (sent < RANDOM_WORDS) begin
         no_idle = (sent >= 200 && sent < 320);
         if (!drained && sent >= 400) begin
            wait_idle();
            drained = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 68) begin
            len = pick_length();
            send_message(32'(len), len + 4);
            sent += len + 4;
         end else if (pick < 76) begin
            send_message(pick_bad_length(), 4);
            cut = $urandom_range(0, 3);
            for (i = 0; i < cut; i++) send_word(KIND_DATA, 8'($urandom()));
            send_word(KIND_OPEN, 8'($urandom()));
            sent += cut + 5;
         end else if (pick < 86) begin
            len = pick_length();
            cut = $urandom_range(1, len + 3);
            send_message(32'(len), cut);
            sent += cut + 1;
            if ($urandom_range(1)) begin
               send_word(KIND_CLOSE, 8'($urandom()));
               send_word(KIND_DATA, 8'($urandom()));
               sent += 2;
            end
            send_word(KIND_OPEN, 8'($urandom()));
         end else if (pick < 92) begin
            send_word(KIND_UNUSED, 8'($urandom()));
         end else begin
            cut = $urandom_range(1, 6);
            for (i = 0; i < cut; i++) send_word(KIND_DATA, 8'($urandom()));
            send_word(KIND_OPEN, 8'($urandom()));
            sent += cut + 1;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      open_s = 1'b1;
      clear_framing();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_length_extremes();
      test_closed_stream();
      test_bad_lengths();
      test_random_stream();
      wait_idle();
      repeat (4) @(posedge clock);
      if (due_words.size() != 0)
         report($sformatf("%0d words never arrived", due_words.size()));
      if (err_count == 0)
         $display("length_prefixed_deframer_tb: done, clean");
      else
         $display("length_prefixed_deframer_tb: done, errors");
      $finish;
   end

endmodule

// ===== length_prefixed_deframer.f =====
rtl/core/lpd_pkg.sv
rtl/core/length_prefixed_deframer.sv
verif/length_prefixed_deframer_tb.sv
